// File: rtl/learning_packet_router_defines.svh
// Assertion macros shared by the router RTL.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef LEARNING_PACKET_ROUTER_DEFINES_SVH
`define LEARNING_PACKET_ROUTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpr assertion failed");

// next-cycle implication, disabled during reset
`define LPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpr assertion failed");

`endif

// File: rtl/lpr_pkg.sv
// Types, sizes and codes for the learning packet router.
// Used by learning_packet_router; depends on nothing.
package lpr_pkg;

  localparam int ADDR_W        = 16;
  localparam int PORT_W        = 3;
  localparam int MASK_W        = 8;
  localparam int ROUTE_ENTRIES = 64;
  localparam int LOCAL_ENTRIES = 16;
  localparam int NUM_PORTS     = 8;
  localparam int RCNT_W        = $clog2(ROUTE_ENTRIES + 1);
  localparam int LCNT_W        = $clog2(LOCAL_ENTRIES + 1);
  localparam int TABLE_DEPTH   = 1 << ADDR_W;

  localparam logic [ADDR_W-1:0] PINNED_ADDR      = 16'h0001;
  localparam logic [ADDR_W-1:0] BCAST_ADDR       = 16'h0000;
  localparam logic [ADDR_W-1:0] RESET_OWN        = 16'h0001;
  localparam logic [ADDR_W-1:0] RESET_UNASSIGNED = 16'hFFFF;

  localparam logic [1:0] CMD_PACKET = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ACT_BROADCAST = 3'd0;
  localparam logic [2:0] ACT_LOCAL     = 3'd1;
  localparam logic [2:0] ACT_FORWARD   = 3'd2;
  localparam logic [2:0] ACT_DROP      = 3'd3;
  localparam logic [2:0] ACT_ADDED     = 3'd4;
  localparam logic [2:0] ACT_REJECTED  = 3'd5;
  localparam logic [2:0] ACT_REMOVED   = 3'd6;

  localparam logic CFG_OWN_ADDRESS     = 1'b0;
  localparam logic CFG_UNASSIGNED_ADDR = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] from_port;
    logic              from_local;
    logic [ADDR_W-1:0] node_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [PORT_W-1:0] out_port;
    logic [MASK_W-1:0] port_mask;
    logic              deliver_local;
    logic              learn_full;
    logic [MASK_W-1:0] ports_seen;
  } rsp_t;

  // one table word per address: learned route and local-node mark
  typedef struct packed {
    logic              route_valid;
    logic [PORT_W-1:0] route_port;
    logic              local_valid;
  } entry_t;

  function automatic logic [MASK_W-1:0] all_ports_mask();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int p = 0; p < MASK_W; p++) begin
      m[p] = (p < NUM_PORTS);
    end
    return m;
  endfunction

  localparam logic [MASK_W-1:0] ALL_PORTS = all_ports_mask();

endpackage

// File: rtl/learning_packet_router.sv
// Learning packet router: forwarding decision and local-node table updates.
// Uses lpr_pkg and the assertion macros in learning_packet_router_defines.svh.
//
// Channels: req (req_valid/req_stall/req) carries a packet header or a local
// node add/remove; rsp (rsp_valid/rsp_stall/rsp) returns one result per
// request. A transfer happens at a clock edge with valid high and stall low.
// Configuration: cfg_write_en writes cfg_data to register cfg_index
// (0 own address, 1 unassigned address); write only while idle.
// The tables live in one address-indexed memory of 65536 words with two read
// ports, so each lookup is a single read; free space is tracked by counts.
// A request's table reads are registered at its transfer; in the lookup state it is
// decided, written back to the shared table memory and registered onto rsp. No new
// request is taken until then, so the read and update/write-back steps never overlap.
// Reset (rst, synchronous): counts, seen mask and registers return to their
// reset values, then a clearing pass writes every table word with req_stall
// held high. Config writes are taken during the pass.
// If rsp is stalled, the finished result waits on rsp, one further request
// can be taken and waits in its update cycle; after that req_stall stays high.
`include "learning_packet_router_defines.svh"

module learning_packet_router (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  lpr_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output lpr_pkg::rsp_t              rsp,
  input  logic                       cfg_write_en,
  input  logic                       cfg_index,
  input  logic [lpr_pkg::ADDR_W-1:0] cfg_data
);
  import lpr_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [ADDR_W-1:0] clear_ptr;
  logic [ADDR_W-1:0] own_address;
  logic [ADDR_W-1:0] unassigned_addr;
  logic [MASK_W-1:0] port_seen;
  logic [MASK_W-1:0] port_seen_next;
  logic [RCNT_W-1:0] route_count;
  logic [RCNT_W-1:0] route_count_next;
  logic [LCNT_W-1:0] local_count;
  logic [LCNT_W-1:0] local_count_next;
  req_t              item;
  rsp_t              rsp_next;

  entry_t            table_mem [TABLE_DEPTH];
  entry_t            rd_a;
  entry_t            rd_b;
  logic [ADDR_W-1:0] raddr_a;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  logic              req_accept;
  logic              go;
  logic              upd_we;
  entry_t            upd_entry;
  entry_t            src_after;
  entry_t            dst_ent;
  logic              learn;

  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign go         = (state == ST_LOOKUP) && (!rsp_valid || !rsp_stall);
  assign raddr_a    = (req.command == CMD_PACKET) ? req.src_addr : req.node_addr;

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (req_accept) begin
      rd_a <= table_mem[raddr_a];
      rd_b <= table_mem[req.dst_addr];
      item <= req;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clear_ptr;
      mem_wdata = '0;
    end else begin
      mem_we    = go && upd_we;
      mem_waddr = (item.command == CMD_PACKET) ? item.src_addr : item.node_addr;
      mem_wdata = upd_entry;
    end
  end

  // decision and read-modify-write for the request held in item
  always_comb begin
    rsp_next         = '0;
    rsp_next.action  = ACT_DROP;
    port_seen_next   = port_seen;
    route_count_next = route_count;
    local_count_next = local_count;
    upd_we           = 1'b0;
    upd_entry        = rd_a;
    src_after        = rd_a;
    dst_ent          = rd_b;
    learn            = !item.from_local && (item.src_addr != unassigned_addr) &&
                       (int'(item.from_port) < NUM_PORTS);
    case (item.command)
      CMD_PACKET: begin
        if (learn) begin
          port_seen_next = port_seen | (MASK_W'(1) << item.from_port);
          if (rd_a.route_valid) begin
            if (item.src_addr != PINNED_ADDR) begin
              src_after.route_port = item.from_port;
              upd_we               = 1'b1;
            end
          end else if (int'(route_count) < ROUTE_ENTRIES) begin
            src_after.route_valid = 1'b1;
            src_after.route_port  = item.from_port;
            upd_we                = 1'b1;
            route_count_next      = route_count + RCNT_W'(1);
          end else begin
            rsp_next.learn_full = 1'b1;
          end
        end
        upd_entry = src_after;
        if (item.dst_addr == item.src_addr) begin
          dst_ent = src_after;
        end
        if (item.dst_addr == BCAST_ADDR) begin
          rsp_next.action        = ACT_BROADCAST;
          rsp_next.deliver_local = 1'b1;
          rsp_next.port_mask     = ALL_PORTS;
          if (src_after.route_valid) begin
            rsp_next.port_mask = ALL_PORTS & ~(MASK_W'(1) << src_after.route_port);
          end
        end else if (item.dst_addr == own_address || dst_ent.local_valid) begin
          rsp_next.action        = ACT_LOCAL;
          rsp_next.deliver_local = 1'b1;
        end else if (dst_ent.route_valid) begin
          rsp_next.action   = ACT_FORWARD;
          rsp_next.out_port = dst_ent.route_port;
        end
      end
      CMD_ADD: begin
        if (item.node_addr == unassigned_addr) begin
          rsp_next.action = ACT_ADDED;
        end else if (rd_a.local_valid) begin
          rsp_next.action = ACT_REJECTED;
        end else if (int'(local_count) < LOCAL_ENTRIES) begin
          upd_entry.local_valid = 1'b1;
          upd_we                = 1'b1;
          local_count_next      = local_count + LCNT_W'(1);
          rsp_next.action       = ACT_ADDED;
        end else begin
          rsp_next.action = ACT_REJECTED;
        end
      end
      CMD_REMOVE: begin
        if (item.node_addr != unassigned_addr && rd_a.local_valid) begin
          upd_entry.local_valid = 1'b0;
          upd_we                = 1'b1;
          local_count_next      = local_count - LCNT_W'(1);
        end
        rsp_next.action = ACT_REMOVED;
      end
      default: begin
        rsp_next.action = ACT_DROP;
      end
    endcase
    rsp_next.ports_seen = port_seen_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clear_ptr == '1) state_next = ST_IDLE;
      ST_IDLE:   if (req_accept) state_next = ST_LOOKUP;
      ST_LOOKUP: if (go) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clear_ptr       <= '0;
      own_address     <= RESET_OWN;
      unassigned_addr <= RESET_UNASSIGNED;
      port_seen       <= '0;
      route_count     <= '0;
      local_count     <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_ptr <= clear_ptr + ADDR_W'(1);
      end
      if (cfg_write_en) begin
        if (cfg_index == CFG_OWN_ADDRESS) begin
          own_address <= cfg_data;
        end else begin
          unassigned_addr <= cfg_data;
        end
      end
      if (go) begin
        port_seen   <= port_seen_next;
        route_count <= route_count_next;
        local_count <= local_count_next;
        rsp_valid   <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp <= rsp_next;
    end
  end

  `LPR_ASSERT_IMPL(a_no_accept_in_clear, state == ST_CLEAR, req_stall)
  `LPR_ASSERT_NEXT(a_accept_to_lookup, req_accept, state == ST_LOOKUP)
  `LPR_ASSERT_IMPL(a_route_count_bound, 1'b1, int'(route_count) <= ROUTE_ENTRIES)
  `LPR_ASSERT_IMPL(a_local_count_bound, 1'b1, int'(local_count) <= LOCAL_ENTRIES)
  `LPR_ASSERT_IMPL(a_full_only_when_full, rsp_valid && rsp.learn_full,
                   int'(route_count) == ROUTE_ENTRIES)

endmodule

// File: sim/learning_packet_router_checker.sv
// Checker for learning_packet_router: predicts each result from the request transfers,
// compares it with the response transfers and counts failures. Uses lpr_pkg.
module learning_packet_router_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_stall,
  input  lpr_pkg::req_t              req,
  input  logic                       rsp_valid,
  input  logic                       rsp_stall,
  input  lpr_pkg::rsp_t              rsp,
  input  logic                       cfg_write_en,
  input  logic                       cfg_index,
  input  logic [lpr_pkg::ADDR_W-1:0] cfg_data,
  output int                         failures,
  output int                         outstanding
);
  import lpr_pkg::*;

  logic [ADDR_W-1:0] own_addr;
  logic [ADDR_W-1:0] unassigned;
  bit                route_live   [ROUTE_ENTRIES];
  logic [ADDR_W-1:0] route_key    [ROUTE_ENTRIES];
  logic [PORT_W-1:0] route_egress [ROUTE_ENTRIES];
  bit                node_live    [LOCAL_ENTRIES];
  logic [ADDR_W-1:0] node_key     [LOCAL_ENTRIES];
  logic [MASK_W-1:0] seen_mask;
  rsp_t              pending_rsp [$];

  initial begin
    failures = 0;
    outstanding = 0;
  end

  function automatic int lookup_route(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < ROUTE_ENTRIES; i++) begin
      if (route_live[i] && route_key[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic int lookup_node(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < LOCAL_ENTRIES; i++) begin
      if (node_live[i] && node_key[i] == addr) return i;
    end
    return -1;
  endfunction

  // forwarding decision plus table update for one request
  function automatic rsp_t route_decision(input req_t r);
    rsp_t e;
    int   hit;
    e = '0;
    e.action = ACT_DROP;
    case (r.command)
      CMD_PACKET: begin
        if (!r.from_local && r.src_addr != unassigned && int'(r.from_port) < NUM_PORTS) begin
          seen_mask[r.from_port] = 1'b1;
          hit = lookup_route(r.src_addr);
          if (hit >= 0) begin
            if (r.src_addr != PINNED_ADDR) route_egress[hit] = r.from_port;
          end else begin
            for (int i = 0; i < ROUTE_ENTRIES && hit < 0; i++) begin
              if (!route_live[i]) hit = i;
            end
            if (hit >= 0) begin
              route_live[hit]   = 1'b1;
              route_key[hit]    = r.src_addr;
              route_egress[hit] = r.from_port;
            end else begin
              e.learn_full = 1'b1;
            end
          end
        end
        if (r.dst_addr == BCAST_ADDR) begin
          e.action = ACT_BROADCAST;
          e.deliver_local = 1'b1;
          e.port_mask = ALL_PORTS;
          hit = lookup_route(r.src_addr);
          if (hit >= 0) e.port_mask[route_egress[hit]] = 1'b0;
        end else if (r.dst_addr == own_addr || lookup_node(r.dst_addr) >= 0) begin
          e.action = ACT_LOCAL;
          e.deliver_local = 1'b1;
        end else begin
          hit = lookup_route(r.dst_addr);
          if (hit >= 0) begin
            e.action = ACT_FORWARD;
            e.out_port = route_egress[hit];
          end
        end
      end
      CMD_ADD: begin
        if (r.node_addr == unassigned) begin
          e.action = ACT_ADDED;
        end else if (lookup_node(r.node_addr) >= 0) begin
          e.action = ACT_REJECTED;
        end else begin
          hit = -1;
          for (int i = 0; i < LOCAL_ENTRIES && hit < 0; i++) begin
            if (!node_live[i]) hit = i;
          end
          if (hit >= 0) begin
            node_live[hit] = 1'b1;
            node_key[hit]  = r.node_addr;
            e.action = ACT_ADDED;
          end else begin
            e.action = ACT_REJECTED;
          end
        end
      end
      CMD_REMOVE: begin
        if (r.node_addr != unassigned) begin
          hit = lookup_node(r.node_addr);
          if (hit >= 0) node_live[hit] = 1'b0;
        end
        e.action = ACT_REMOVED;
      end
      default: ;
    endcase
    e.ports_seen = seen_mask;
    return e;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      own_addr   = RESET_OWN;
      unassigned = RESET_UNASSIGNED;
      seen_mask  = '0;
      for (int i = 0; i < ROUTE_ENTRIES; i++) route_live[i] = 1'b0;
      for (int i = 0; i < LOCAL_ENTRIES; i++) node_live[i] = 1'b0;
      pending_rsp.delete();
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == CFG_OWN_ADDRESS) own_addr = cfg_data;
        else unassigned = cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $error("result transfer with no request outstanding");
          failures++;
        end else begin
          want = pending_rsp.pop_front();
          check_field("action", 16'(want.action), 16'(rsp.action));
          check_field("out_port", 16'(want.out_port), 16'(rsp.out_port));
          check_field("port_mask", 16'(want.port_mask), 16'(rsp.port_mask));
          check_field("deliver_local", 16'(want.deliver_local), 16'(rsp.deliver_local));
          check_field("learn_full", 16'(want.learn_full), 16'(rsp.learn_full));
          check_field("ports_seen", 16'(want.ports_seen), 16'(rsp.ports_seen));
        end
      end
      if (req_valid && !req_stall) pending_rsp.push_back(route_decision(req));
    end
    outstanding = pending_rsp.size();
  end

endmodule

// File: sim/learning_packet_router_test.sv
// Testbench top for learning_packet_router: clock, reset, register writes and
// request/result traffic. Needs lpr_pkg, the RTL and learning_packet_router_checker.
module learning_packet_router_test;
  import lpr_pkg::*;

  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         PHASE_ITEMS   = 120;
  localparam int         LONG_HOLD     = 120;

  logic              clk;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              cfg_write_en = 1'b0;
  logic              cfg_index = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  int                failures;
  int                outstanding;
  int                cycle_count = 0;
  bit                sender_idle = 1'b1;
  bit                receiver_idle = 1'b1;
  bit                hold_off_pending = 1'b0;
  int                wild_pct = 5;
  logic [ADDR_W-1:0] addr_pool [16];

  learning_packet_router i_dut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_write_en, .cfg_index, .cfg_data
  );

  learning_packet_router_checker i_checker (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_write_en, .cfg_index, .cfg_data, .failures, .outstanding
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random hold-off per transfer, one long hold on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = receiver_idle ? $urandom_range(0, 6) : 0;
      if (hold_off_pending) begin
        n = LONG_HOLD;
        hold_off_pending = 1'b0;
      end
      if (n > 0) begin
        rsp_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      rsp_stall = 1'b0;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 99) < wild_pct) return ADDR_W'($urandom);
    return addr_pool[$urandom_range(0, 15)];
  endfunction

  function automatic req_t make_req(input logic [1:0] cmd, input logic [ADDR_W-1:0] src,
                                    input logic [ADDR_W-1:0] dst, input logic [2:0] port,
                                    input logic from_local, input logic [ADDR_W-1:0] node);
    req_t r;
    r.command    = cmd;
    r.src_addr   = src;
    r.dst_addr   = dst;
    r.from_port  = port;
    r.from_local = from_local;
    r.node_addr  = node;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) r.command = CMD_PACKET;
    else if (roll < 83) r.command = CMD_ADD;
    else if (roll < 96) r.command = CMD_REMOVE;
    else r.command = CMD_UNDEFINED;
    r.src_addr   = pick_addr();
    r.dst_addr   = ($urandom_range(0, 99) < 15) ? BCAST_ADDR : pick_addr();
    r.from_port  = PORT_W'($urandom_range(0, 7));
    r.from_local = ($urandom_range(0, 99) < 15);
    r.node_addr  = pick_addr();
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input req_t r);
    int gap;
    gap = sender_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [ADDR_W-1:0] value);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] own_set [4];
    logic [ADDR_W-1:0] unas_set [4];
    int                wild_set [4];
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'h0001;
    addr_pool[2] = 16'hFFFF;
    addr_pool[3] = 16'hFFFE;
    addr_pool[4] = 16'h8000;
    addr_pool[5] = 16'h7FFF;
    for (int i = 6; i < 16; i++) addr_pool[i] = ADDR_W'($urandom);
    own_set  = '{16'h0001, 16'h0000, 16'hFFFF, addr_pool[8]};
    unas_set = '{16'hFFFF, 16'h0000, 16'h0001, addr_pool[9]};
    wild_set = '{5, 8, 40, 10};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_register(CFG_OWN_ADDRESS, own_set[phase]);
      write_register(CFG_UNASSIGNED_ADDR, unas_set[phase]);
      wild_pct = wild_set[phase];
      if (phase == 0) begin
        // pinned route, unknown-source broadcast, drop, forward and relearn
        send_request(make_req(CMD_PACKET, 16'h0001, BCAST_ADDR, 3'd3, 1'b0, 16'h0000));
        send_request(make_req(CMD_PACKET, 16'h0001, BCAST_ADDR, 3'd5, 1'b0, 16'hFFFF));
        send_request(make_req(CMD_PACKET, 16'hFFFF, BCAST_ADDR, 3'd7, 1'b0, 16'h0000));
        send_request(make_req(CMD_PACKET, 16'h1234, 16'h0001, 3'd2, 1'b1, 16'h0000));
        send_request(make_req(CMD_PACKET, 16'hABCD, 16'h1234, 3'd0, 1'b0, 16'h0000));
        send_request(make_req(CMD_PACKET, 16'h1234, 16'hABCD, 3'd7, 1'b0, 16'h0000));
        send_request(make_req(CMD_PACKET, 16'hABCD, 16'h1234, 3'd6, 1'b0, 16'h0000));
        send_request(make_req(CMD_PACKET, 16'h5555, 16'hFFFF, 3'd2, 1'b0, 16'h0000));
        send_request(make_req(CMD_PACKET, 16'hFFFE, 16'h0001, 3'd4, 1'b0, 16'h0000));
        // local node table: add, duplicate, unassigned, removal
        send_request(make_req(CMD_ADD, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h1234));
        send_request(make_req(CMD_ADD, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h1234));
        send_request(make_req(CMD_ADD, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'hFFFF));
        send_request(make_req(CMD_PACKET, 16'h0000, 16'h1234, 3'd1, 1'b0, 16'h0000));
        send_request(make_req(CMD_REMOVE, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h1234));
        send_request(make_req(CMD_REMOVE, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h1234));
        send_request(make_req(CMD_REMOVE, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'hFFFF));
        send_request(make_req(CMD_PACKET, 16'h8000, 16'h1234, 3'd3, 1'b0, 16'h0000));
        send_request(make_req(CMD_UNDEFINED, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 16'hFFFF));
        send_request(make_req(CMD_PACKET, 16'h0001, BCAST_ADDR, 3'd7, 1'b1, 16'h0000));
        drain();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) begin
          sender_idle = ($urandom_range(0, 2) != 0);
          receiver_idle = ($urandom_range(0, 2) != 0);
          if (phase == 1 && n == 0) begin
            sender_idle = 1'b0;
            hold_off_pending = 1'b1;
          end
        end
        send_request(random_request());
      end
    end

    drain();
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lpr_pkg.sv
rtl/learning_packet_router.sv
sim/learning_packet_router_checker.sv
sim/learning_packet_router_test.sv
